### rtl/bml_pkg.sv
`timescale 1ns / 1ps

package bml_pkg;

	localparam int          LANES       = 4;
	localparam logic [7:0]  FILL_BYTE   = 8'ha5;
	localparam logic        OP_READ     = 1'b0;
	localparam logic        OP_WRITE    = 1'b1;
	localparam logic [1:0]  SZ_BYTE     = 2'd0;
	localparam logic [1:0]  SZ_HALF     = 2'd1;
	localparam logic [1:0]  SZ_WORD     = 2'd2;
	localparam logic [1:0]  SZ_ALT_WORD = 2'd3;  // decodes as a word
	localparam logic [31:0] SIZE_MASK   = 32'hfffffff0;

	typedef logic [LANES-1:0][7:0] lane_bytes_t;

	typedef struct packed {
		logic [LANES-1:0] lane_we;  // per lane
		logic [LANES-1:0] byte_ok;  // per access byte: used and in range
		logic             bad;
	} agen_t;

endpackage

### rtl/byte_memory_le_access.sv
`timescale 1ns / 1ps
// Item reads and controls register in stage s1, the result then in the output
// register. Throughput: one item per cycle unless m_axis_tready stalls the
// output; four byte-lane RAMs with one port each serve any aligned or unaligned
// access of up to four bytes. Reset: a fill sweep writes 0xa5 to all MEM_SIZE
// bytes (MEM_BYTES rounded up to 16); no item is accepted until it ends.
module byte_memory_le_access #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[0], access_size[2:1], sign_extend[3], byte_address[35:4],
	// write_value[67:36], zero [71:68]
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_value[31:0], range_error[32], zero [39:33]
	output logic [39:0] m_axis_tdata
);

	localparam logic [32:0] MEM_SIZE =
		33'((MEM_BYTES + 15) / 16 * 16);
	localparam int DEPTH = (MEM_BYTES + 15) / 16 * 4;
	localparam int RW    = $clog2(DEPTH);

	logic                                op;
	logic [1:0]                          access_size;
	logic                                sign_extend;
	logic [31:0]                         byte_address;
	logic [31:0]                         write_value;

	logic                                sweep_busy;
	logic [RW-1:0]                       sweep_row;
	logic [bml_pkg::LANES-1:0][RW-1:0]   rows;
	bml_pkg::lane_bytes_t                wbytes;
	bml_pkg::lane_bytes_t                rdata;
	bml_pkg::agen_t                      ctl;
	logic                                accept;
	logic                                s1_adv;

	logic                                valid_s1;
	logic                                op_s1;
	logic [1:0]                          size_s1;
	logic                                sx_s1;
	logic [1:0]                          lo_s1;
	logic [bml_pkg::LANES-1:0]           ok_s1;
	logic                                bad_s1;

	logic                                out_valid_q;
	logic [31:0]                         out_data_q;
	logic                                out_err_q;
	logic [31:0]                         data_s1;

	assign op           = s_axis_tdata[0];
	assign access_size  = s_axis_tdata[2:1];
	assign sign_extend  = s_axis_tdata[3];
	assign byte_address = s_axis_tdata[35:4];
	assign write_value  = s_axis_tdata[67:36];

	bml_sweep #(.DEPTH(DEPTH)) u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (sweep_busy),
		.row    (sweep_row)
	);

	bml_agen #(.ROW_W(RW), .MEM_SIZE(MEM_SIZE)) u_agen (
		.op           (op),
		.access_size  (access_size),
		.byte_address (byte_address),
		.write_value  (write_value),
		.rows         (rows),
		.wbytes       (wbytes),
		.ctl          (ctl)
	);

	assign s1_adv        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !sweep_busy && (!valid_s1 || s1_adv);
	assign accept        = s_axis_tvalid && s_axis_tready;

	for (genvar j = 0; j < bml_pkg::LANES; j++) begin : g_lane
		bml_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
			.clk   (clk),
			.en    (sweep_busy || accept),
			.we    (sweep_busy || ctl.lane_we[j]),
			.addr  (sweep_busy ? sweep_row : rows[j]),
			.wdata (sweep_busy ? bml_pkg::FILL_BYTE : wbytes[j]),
			.rdata (rdata[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			size_s1 <= access_size;
			sx_s1   <= sign_extend;
			lo_s1   <= byte_address[1:0];
			ok_s1   <= ctl.byte_ok;
			bad_s1  <= ctl.bad;
		end
	end

	always_comb begin
		logic [1:0] lane;
		data_s1 = '0;
		for (int k = 0; k < bml_pkg::LANES; k++) begin
			lane = lo_s1 + 2'(k);
			if (ok_s1[k]) begin
				data_s1[8*k +: 8] = rdata[lane];
			end
		end
		if (sx_s1) begin
			if (size_s1 == bml_pkg::SZ_BYTE && data_s1[7]) begin
				data_s1[31:8] = '1;
			end else if (size_s1 == bml_pkg::SZ_HALF && data_s1[15]) begin
				data_s1[31:16] = '1;
			end
		end
		if (op_s1 == bml_pkg::OP_WRITE) begin
			data_s1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			out_data_q <= data_s1;
			out_err_q  <= bad_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_err_q, out_data_q};

endmodule

### rtl/bml_ram.sv
`timescale 1ns / 1ps

module bml_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

### rtl/bml_sweep.sv
`timescale 1ns / 1ps

module bml_sweep #(
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     arst_n,
	output logic                     busy,
	output logic [$clog2(DEPTH)-1:0] row
);

	localparam int RW = $clog2(DEPTH);

	logic [RW-1:0] cnt_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (cnt_q == RW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign busy = busy_q;
	assign row  = cnt_q;

endmodule

### rtl/bml_agen.sv
`timescale 1ns / 1ps

module bml_agen #(
	parameter int          ROW_W    = 14,
	parameter logic [32:0] MEM_SIZE = 33'd65536
) (
	input  logic                                   op,
	input  logic [1:0]                             access_size,
	input  logic [31:0]                            byte_address,
	input  logic [31:0]                            write_value,
	output logic [bml_pkg::LANES-1:0][ROW_W-1:0]  rows,
	output bml_pkg::lane_bytes_t                  wbytes,
	output bml_pkg::agen_t                        ctl
);

	always_comb begin
		logic [1:0]  k;
		logic [31:0] a;
		logic        used;
		logic        inr;
		ctl  = '0;
		rows = '0;
		wbytes = '0;
		for (int j = 0; j < bml_pkg::LANES; j++) begin
			k    = 2'(j) - byte_address[1:0];
			a    = byte_address + {30'd0, k};
			used = (k == 2'd0) || (k == 2'd1 && access_size != bml_pkg::SZ_BYTE)
				|| access_size[1];
			inr  = {1'b0, a} < MEM_SIZE;
			rows[j]        = a[ROW_W+1:2];
			wbytes[j]      = write_value[8*k +: 8];
			ctl.lane_we[j] = (op == bml_pkg::OP_WRITE) && used && inr;
			ctl.byte_ok[k] = used && inr;
			if (used && !inr) begin
				ctl.bad = 1'b1;
			end
		end
	end

endmodule

### tb/sv/bml_access_checker.sv
`timescale 1ns / 1ps

module bml_access_checker #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// op[0], access_size[2:1], sign_extend[3], byte_address[35:4],
	// write_value[67:36], zero [71:68]
	input  logic [71:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// read_value[31:0], range_error[32], zero [39:33]
	input  logic [39:0] m_tdata,
	output int          fail_count,
	output int          pending_results
);

	localparam int unsigned MEM_SIZE = (MEM_BYTES + 15) & bml_pkg::SIZE_MASK;
	localparam int          MW       = $clog2(MEM_SIZE);

	typedef struct packed {
		logic [31:0] read_value;
		logic        range_error;
	} mem_result_t;

	logic [7:0]  mirror_mem [0:MEM_SIZE-1];
	mem_result_t access_results_q [$];

	task automatic report_mismatch(input string what);
		$display("%0t ns: checker: %s", $time, what);
		fail_count++;
	endtask

	// Updates the mirror on writes and returns the result the access should give.
	function automatic mem_result_t predict_access(input logic [71:0] word);
		logic        op;
		logic [1:0]  sz;
		logic        sx;
		logic [31:0] addr;
		logic [31:0] wval;
		logic [31:0] a;
		logic [31:0] data;
		int          nbytes;
		mem_result_t res;
		op   = word[0];
		sz   = word[2:1];
		sx   = word[3];
		addr = word[35:4];
		wval = word[67:36];
		data = '0;
		res.range_error = 1'b0;
		nbytes = (sz == bml_pkg::SZ_BYTE) ? 1 : (sz == bml_pkg::SZ_HALF) ? 2 : 4;
		for (int k = 0; k < nbytes; k++) begin
			a = addr + 32'(k);
			if (a >= MEM_SIZE)
				res.range_error = 1'b1;
			else if (op == bml_pkg::OP_WRITE)
				mirror_mem[a[MW-1:0]] = wval[8*k +: 8];
			else
				data[8*k +: 8] = mirror_mem[a[MW-1:0]];
		end
		// sign extension works on the assembled value, zero bytes included
		if (op == bml_pkg::OP_READ && sx) begin
			if (nbytes == 1 && data[7])
				data[31:8] = '1;
			else if (nbytes == 2 && data[15])
				data[31:16] = '1;
		end
		res.read_value = data;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mem_result_t exp_res;
		if (!arst_n) begin
			for (int i = 0; i < MEM_SIZE; i++)
				mirror_mem[MW'(i)] = bml_pkg::FILL_BYTE;
			access_results_q.delete();
			fail_count      = 0;
			pending_results = 0;
		end else begin
			if (s_tvalid && s_tready)
				access_results_q.push_back(predict_access(s_tdata));
			if (m_tvalid && m_tready) begin
				if (access_results_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", m_tdata));
				end else begin
					exp_res = access_results_q.pop_front();
					if (m_tdata[31:0] !== exp_res.read_value)
						report_mismatch($sformatf("read_value %h, expected %h",
							m_tdata[31:0], exp_res.read_value));
					if (m_tdata[32] !== exp_res.range_error)
						report_mismatch($sformatf("range_error %b, expected %b",
							m_tdata[32], exp_res.range_error));
				end
			end
			pending_results = access_results_q.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int          MEM_BYTES   = 65536;
	localparam int unsigned MEM_SIZE    = (MEM_BYTES + 15) & bml_pkg::SIZE_MASK;
	localparam int          CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	int          fail_count;
	int          pending_results;
	int          cycle_cnt = 0;
	int          stall_left = 0;
	logic        idle_on = 1'b1;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	byte_memory_le_access #(
		.MEM_BYTES(MEM_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	bml_access_checker #(
		.MEM_BYTES(MEM_BYTES)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_axis_tvalid),
		.s_tready       (s_axis_tready),
		.s_tdata        (s_axis_tdata),
		.m_tvalid       (m_axis_tvalid),
		.m_tready       (m_axis_tready),
		.m_tdata        (m_axis_tdata),
		.fail_count     (fail_count),
		.pending_results(pending_results)
	);

	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Called and returns at a falling edge.
	task automatic send_access(input logic op, input logic [1:0] sz, input logic sx,
			input logic [31:0] addr, input logic [31:0] wval);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, wval, addr, sx, sz, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [31:0] addr;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// fill pattern, with and without sign extension
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_BYTE, 1'b0, 32'h0, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_BYTE, 1'b1, 32'h1, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_HALF, 1'b1, 32'h3, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_WORD, 1'b1, 32'h5, 32'h0);
		// writes and read-backs, sign_extend ignored on writes, size three as a word
		send_access(bml_pkg::OP_WRITE, bml_pkg::SZ_WORD, 1'b1, 32'h10, 32'hffffffff);
		send_access(bml_pkg::OP_WRITE, bml_pkg::SZ_ALT_WORD, 1'b0, 32'h20, 32'h80017f80);
		send_access(bml_pkg::OP_WRITE, bml_pkg::SZ_HALF, 1'b0, 32'h31, 32'h12348000);
		send_access(bml_pkg::OP_WRITE, bml_pkg::SZ_BYTE, 1'b0, 32'h40, 32'h0000007f);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_ALT_WORD, 1'b1, 32'h20, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_HALF, 1'b1, 32'h31, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_HALF, 1'b0, 32'h31, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_BYTE, 1'b1, 32'h20, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_BYTE, 1'b1, 32'h40, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_WORD, 1'b0, 32'h10, 32'h0);
		// top of the store: partial writes and reads, zero bytes then extension
		send_access(bml_pkg::OP_WRITE, bml_pkg::SZ_WORD, 1'b0, MEM_SIZE - 2, 32'hdeadbe80);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_WORD, 1'b1, MEM_SIZE - 2, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_HALF, 1'b1, MEM_SIZE - 1, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_BYTE, 1'b1, MEM_SIZE, 32'h0);
		// address wrap past the top of the 32-bit space
		send_access(bml_pkg::OP_WRITE, bml_pkg::SZ_WORD, 1'b0, 32'hffffffff, 32'h01020304);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_WORD, 1'b0, 32'hfffffffe, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_HALF, 1'b1, 32'hfffffffe, 32'h0);
		send_access(bml_pkg::OP_READ,  bml_pkg::SZ_WORD, 1'b0, 32'h0, 32'h0);
		drain_results();

		for (int i = 0; i < 1200; i++) begin
			if (i % 100 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (i >= 1000)
				idle_on = 1'b0;
			if (i == 400 || i == 800)
				drain_results();
			case ($urandom_range(0, 19))
				0, 1, 2:  addr = MEM_SIZE - 8 + $urandom_range(0, 15);
				3, 4:     addr = 32'hfffffff8 + $urandom_range(0, 7);
				5, 6, 7:  addr = $urandom;
				8:        addr = $urandom_range(0, MEM_SIZE - 1);
				default:  addr = $urandom_range(0, 255);
			endcase
			send_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), addr, $urandom);
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
